[design/vpw_pkg.sv]
package vpw_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;
  localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
  localparam int TERM_WIDTH  = PROD_WIDTH - FRAC_BITS;
  localparam int DIV_STEPS   = COORD_WIDTH + FRAC_BITS;
  localparam int NUM_COEFS   = 32;
  localparam int COEF_IDX_W  = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int VP_POS_W   = 16;
  localparam int VP_SIZE_W  = 15;

  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_HEIGHT = 2'd3;

  localparam logic OP_WRITE_COEF = 1'b0;
  localparam logic OP_PROJECT    = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_Z_ZERO  = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [COORD_WIDTH-1:0]        umag_t;
  typedef logic [DIV_STEPS-1:0]          divq_t;

  localparam coord_t ONE_Q  = coord_t'(64'sd1 <<< FRAC_BITS);
  localparam coord_t HALF_Q = coord_t'(64'sd1 <<< (FRAC_BITS - 1));
  localparam coord_t MAX_Q  = coord_t'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam coord_t MIN_Q  = coord_t'(-(64'sd1 <<< (COORD_WIDTH - 1)));

  typedef struct packed {
    umag_t rem;
    divq_t nq;
  } div_lane_t;

  function automatic coord_t sat_coord(input logic signed [63:0] v);
    coord_t r;
    if (v > 64'(MAX_Q)) r = MAX_Q;
    else if (v < 64'(MIN_Q)) r = MIN_Q;
    else r = coord_t'(v);
    return r;
  endfunction

  function automatic umag_t mag_of(input coord_t v);
    umag_t r;
    r = v[COORD_WIDTH-1] ? umag_t'(-v) : umag_t'(v);
    return r;
  endfunction

  // One restoring division step: the next dividend bit moves into the
  // remainder and the quotient bit moves into the freed low end.
  function automatic div_lane_t div_step(input div_lane_t l, input umag_t ub);
    logic [COORD_WIDTH:0] t;
    logic                 ge;
    div_lane_t            r;
    t  = {l.rem, l.nq[DIV_STEPS-1]};
    ge = (t >= {1'b0, ub});
    r.rem = ge ? umag_t'(t - {1'b0, ub}) : umag_t'(t);
    r.nq  = {l.nq[DIV_STEPS-2:0], ge};
    return r;
  endfunction

  function automatic logic is_diag(input int i);
    return ((i % 16) % 5) == 0;
  endfunction

endpackage

[design/vpw_if.sv]
interface vpw_in_if;
  import vpw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [COEF_IDX_W-1:0] coef_index;
  coord_t                coef_value;
  coord_t                model_x;
  coord_t                model_y;
  coord_t                model_z;
  modport source (output valid, opcode, coef_index, coef_value, model_x, model_y, model_z,
                  input ready);
  modport sink (input valid, opcode, coef_index, coef_value, model_x, model_y, model_z,
                output ready);
endinterface

interface vpw_out_if;
  import vpw_pkg::*;
  logic   valid;
  logic   ready;
  logic   status;
  coord_t screen_x;
  coord_t screen_y;
  coord_t screen_depth;
  modport source (output valid, status, screen_x, screen_y, screen_depth, input ready);
  modport sink (input valid, status, screen_x, screen_y, screen_depth, output ready);
endinterface

[design/vertex_project_to_window.sv]
// Projects a model-space vertex to window coordinates through a view matrix and a
// projection matrix held in a 32-word coefficient store (identity after reset).
// Opcode 0 writes one coefficient and returns nothing; opcode 1 projects a vertex and
// returns one transaction. Coefficients are sampled when a vertex is accepted, so a
// write affects only later vertices. A vertex may enter every cycle while the output is
// not stalled. The pipeline has four stages for the two matrix products, 48 single-bit
// stages of the restoring perspective divider, and three for viewport mapping and
// saturation. A stalled output holds the whole pipeline.
module vertex_project_to_window (
  input  logic                           clk,
  input  logic                           rst_n,
  vpw_in_if.sink                         in_ch,
  vpw_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [vpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vpw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vpw_pkg::*;

  logic en;
  logic acc;

  coord_t                 coef_r [NUM_COEFS];
  logic signed [VP_POS_W-1:0] vp_x_r, vp_y_r;
  logic [VP_SIZE_W-1:0]   vp_w_r, vp_h_r;

  // stage 1: view products
  logic                         s1_v_r;
  logic signed [PROD_WIDTH-1:0] s1_m_r [4][3];
  coord_t                       s1_t_r [4];
  coord_t                       s1_pc_r [3][4];
  // stage 2: eye
  logic   s2_v_r;
  coord_t s2_eye_r [4];
  coord_t s2_pc_r [3][4];
  // stage 3: projection products
  logic                         s3_v_r;
  logic signed [PROD_WIDTH-1:0] s3_m_r [3][4];
  coord_t                       s3_ez_r;
  // stage 4: clip
  logic   s4_v_r;
  coord_t s4_clip_r [3];
  coord_t s4_ez_r;

  // divider
  logic      d_v_r    [DIV_STEPS];
  logic      d_zero_r [DIV_STEPS];
  logic [2:0] d_neg_r [DIV_STEPS];
  umag_t     d_ub_r   [DIV_STEPS];
  div_lane_t d_l_r    [DIV_STEPS][3];
  div_lane_t d_nxt    [DIV_STEPS][3];

  // post stages
  logic   p1_v_r, p1_zero_r;
  coord_t p1_ndc_r [3];
  logic   p2_v_r, p2_zero_r;
  logic signed [COORD_WIDTH+VP_SIZE_W+1:0] p2_px_r, p2_py_r;
  coord_t p2_dep_r;
  logic   out_v_r, out_st_r;
  coord_t out_x_r, out_y_r, out_d_r;

  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;
  assign acc         = in_ch.valid && en;

  // Configuration and coefficient store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_x_r <= '0;
      vp_y_r <= '0;
      vp_w_r <= VP_SIZE_W'(1);
      vp_h_r <= VP_SIZE_W'(1);
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_r[i] <= is_diag(i) ? ONE_Q : '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_VIEWPORT_X:      vp_x_r <= signed'(cfg_data[VP_POS_W-1:0]);
          REG_VIEWPORT_Y:      vp_y_r <= signed'(cfg_data[VP_POS_W-1:0]);
          REG_VIEWPORT_WIDTH:  vp_w_r <= cfg_data[VP_SIZE_W-1:0];
          REG_VIEWPORT_HEIGHT: vp_h_r <= cfg_data[VP_SIZE_W-1:0];
          default: ;
        endcase
      end
      if (acc && in_ch.opcode == OP_WRITE_COEF) begin
        coef_r[in_ch.coef_index] <= in_ch.coef_value;
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int k = 0; k < DIV_STEPS; k++) d_v_r[k] <= 1'b0;
    end else if (en) begin
      s1_v_r   <= acc && in_ch.opcode == OP_PROJECT;
      s2_v_r   <= s1_v_r;
      s3_v_r   <= s2_v_r;
      s4_v_r   <= s3_v_r;
      d_v_r[0] <= s4_v_r;
      for (int k = 1; k < DIV_STEPS; k++) d_v_r[k] <= d_v_r[k-1];
      p1_v_r   <= d_v_r[DIV_STEPS-1];
      p2_v_r   <= p1_v_r;
      out_v_r  <= p2_v_r;
    end
  end

  // Divider steps, one per stage.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      d_nxt[0][j] = div_step('{rem: '0, nq: {mag_of(s4_clip_r[j]), FRAC_BITS'(0)}},
                             mag_of(s4_ez_r));
    end
    for (int k = 1; k < DIV_STEPS; k++) begin
      for (int j = 0; j < 3; j++) begin
        d_nxt[k][j] = div_step(d_l_r[k-1][j], d_ub_r[k-1]);
      end
    end
  end

  // Each product term keeps its full magnitude, so the sums are wide enough for
  // three or four terms before saturation.
  logic signed [TERM_WIDTH+2:0]  sum_e [4];
  logic signed [TERM_WIDTH+2:0]  sum_c [3];
  logic signed [COORD_WIDTH+1:0] ndc_half [2];
  logic signed [COORD_WIDTH:0]   dep_sum;
  divq_t                         q_fin [3];
  coord_t                        ndc_n [3];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_e[r] = (TERM_WIDTH+3)'(s1_t_r[r]);
      for (int c = 0; c < 3; c++) begin
        sum_e[r] = sum_e[r] + (TERM_WIDTH+3)'(s1_m_r[r][c] >>> FRAC_BITS);
      end
    end
    for (int r = 0; r < 3; r++) begin
      sum_c[r] = '0;
      for (int c = 0; c < 4; c++) begin
        sum_c[r] = sum_c[r] + (TERM_WIDTH+3)'(s3_m_r[r][c] >>> FRAC_BITS);
      end
    end
    for (int j = 0; j < 3; j++) begin
      q_fin[j] = d_l_r[DIV_STEPS-1][j].nq;
      if (d_neg_r[DIV_STEPS-1][j]) begin
        ndc_n[j] = (q_fin[j] > DIV_STEPS'(umag_t'(MIN_Q))) ? MIN_Q
                 : coord_t'(-q_fin[j]);
      end else begin
        ndc_n[j] = (q_fin[j] > DIV_STEPS'(umag_t'(MAX_Q))) ? MAX_Q : coord_t'(q_fin[j]);
      end
    end
    for (int j = 0; j < 2; j++) begin
      ndc_half[j] = (COORD_WIDTH+2)'(p1_ndc_r[j] >>> 1) + (COORD_WIDTH+2)'(HALF_Q);
    end
    dep_sum = ((COORD_WIDTH+1)'(p1_ndc_r[2]) + (COORD_WIDTH+1)'(ONE_Q)) >>> 1;
  end

  // Datapath registers; they need no reset.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        s1_m_r[r][0] <= coef_r[r]     * in_ch.model_x;
        s1_m_r[r][1] <= coef_r[r + 4] * in_ch.model_y;
        s1_m_r[r][2] <= coef_r[r + 8] * in_ch.model_z;
        s1_t_r[r]    <= coef_r[r + 12];
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          s1_pc_r[r][c] <= coef_r[16 + r + 4 * c];
        end
      end

      for (int r = 0; r < 4; r++) s2_eye_r[r] <= sat_coord(64'(sum_e[r]));
      s2_pc_r <= s1_pc_r;

      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          s3_m_r[r][c] <= s2_pc_r[r][c] * s2_eye_r[c];
        end
      end
      s3_ez_r <= s2_eye_r[2];

      for (int r = 0; r < 3; r++) s4_clip_r[r] <= sat_coord(64'(sum_c[r]));
      s4_ez_r <= s3_ez_r;

      // The divisor is the negated eye z, so a positive eye z flips the sign.
      d_zero_r[0] <= (s4_ez_r == '0);
      d_ub_r[0]   <= mag_of(s4_ez_r);
      for (int j = 0; j < 3; j++) begin
        d_neg_r[0][j] <= s4_clip_r[j][COORD_WIDTH-1] != (s4_ez_r > 0);
        d_l_r[0][j]   <= d_nxt[0][j];
      end
      for (int k = 1; k < DIV_STEPS; k++) begin
        d_zero_r[k] <= d_zero_r[k-1];
        d_ub_r[k]   <= d_ub_r[k-1];
        d_neg_r[k]  <= d_neg_r[k-1];
        for (int j = 0; j < 3; j++) d_l_r[k][j] <= d_nxt[k][j];
      end

      p1_zero_r <= d_zero_r[DIV_STEPS-1];
      p1_ndc_r  <= ndc_n;

      p2_zero_r <= p1_zero_r;
      p2_px_r   <= ndc_half[0] * signed'({1'b0, vp_w_r});
      p2_py_r   <= ndc_half[1] * signed'({1'b0, vp_h_r});
      p2_dep_r  <= sat_coord(64'(dep_sum));

      out_st_r <= p2_zero_r ? STATUS_Z_ZERO : STATUS_OK;
      out_x_r  <= p2_zero_r ? '0
                : sat_coord(64'(p2_px_r) + (64'(vp_x_r) <<< FRAC_BITS));
      out_y_r  <= p2_zero_r ? '0
                : sat_coord(64'(p2_py_r) + (64'(vp_y_r) <<< FRAC_BITS));
      out_d_r  <= p2_zero_r ? '0 : p2_dep_r;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.status       = out_st_r;
  assign out_ch.screen_x     = out_x_r;
  assign out_ch.screen_y     = out_y_r;
  assign out_ch.screen_depth = out_d_r;

endmodule

[design/vpw_checker.sv]
module vpw_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_status,
  input logic [vpw_pkg::COORD_WIDTH-1:0] out_x,
  input logic [vpw_pkg::COORD_WIDTH-1:0] out_y,
  input logic [vpw_pkg::COORD_WIDTH-1:0] out_depth
);
  import vpw_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output register is empty");

  a_zero_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_Z_ZERO |-> out_x == '0 && out_y == '0 && out_depth == '0)
    else $error("failed projection carries non-zero coordinates");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_depth) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind vertex_project_to_window vpw_checker u_vpw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_status(out_ch.status),
  .out_x     (out_ch.screen_x),
  .out_y     (out_ch.screen_y),
  .out_depth (out_ch.screen_depth)
);
